// ===== rtl/core/dcp_pkg.sv =====
// Package for the digest cache with tree pseudo-LRU replacement.
// Holds the item, result and line layouts and the engine state type.
// No dependencies.
package dcp_pkg;

    localparam int unsigned TOP_W  = 32;
    localparam int unsigned MID_W  = 64;
    localparam int unsigned BOT_W  = 64;
    localparam int unsigned POS_W  = 64;
    localparam int unsigned DIG_W  = TOP_W + MID_W + BOT_W;
    // line word: {valid, position, bottom, middle, top}
    localparam int unsigned LINE_W = DIG_W + POS_W + 1;
    localparam int unsigned ITEM_W = DIG_W + POS_W;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [BOT_W-1:0] bot;
        logic [MID_W-1:0] mid;
        logic [TOP_W-1:0] top;
    } t_item;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_AWAY,
        S_WALK_RD,
        S_WALK_WR,
        S_INSERT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/dcp_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dcp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dcp_front.sv =====
// Front end: takes input beats and holds them in a two-entry queue
// ahead of the lookup engine. Depends on dcp_pkg.
module dcp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dcp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output dcp_pkg::t_item o_item
);

    dcp_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/dcp_engine.sv =====
// Back end: clearing pass, associative sweep of the line RAM, tree
// pseudo-LRU update or victim walk, line insert and result register.
// Depends on dcp_pkg and dcp_ram.
module dcp_engine #(
    parameter int unsigned LOG_LINES = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dcp_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output dcp_pkg::t_result o_res
);

    localparam int unsigned LINES = 2 ** LOG_LINES;
    localparam int unsigned LVL_W = $clog2(LOG_LINES + 1);
    localparam logic [LOG_LINES:0] INNER_N = (LOG_LINES + 1)'(LINES - 1);

    dcp_pkg::t_state          r_state, n_state;
    logic [LOG_LINES-1:0]     r_cnt, n_cnt;
    logic                     r_all, n_all;
    logic                     r_rd_vld;
    logic [LOG_LINES-1:0]     r_rd_idx;
    logic [LOG_LINES:0]       r_node, n_node;
    logic [LVL_W-1:0]         r_lvl, n_lvl;
    dcp_pkg::t_item           r_item;
    dcp_pkg::t_result         r_res, n_res;
    logic                     r_ovalid;
    dcp_pkg::t_result         r_ores;

    logic                       l_we, l_re;
    logic [LOG_LINES-1:0]       l_waddr;
    logic [dcp_pkg::LINE_W-1:0] l_wdata, l_rdata;
    logic                       t_we, t_re;
    logic [LOG_LINES-1:0]       t_waddr, t_raddr;
    logic                       t_wdata, t_rdata;

    logic                 issue;
    logic                 match;
    logic                 take;
    logic                 out_free;
    logic [LOG_LINES:0]   up;
    logic [LOG_LINES:0]   nxt;

    dcp_ram #(.WIDTH(dcp_pkg::LINE_W), .DEPTH(LINES)) u_lines (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (r_cnt),
        .o_rdata (l_rdata)
    );

    dcp_ram #(.WIDTH(1), .DEPTH(LINES)) u_tree (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    // shared datapath terms
    assign issue    = (r_state == dcp_pkg::S_SEARCH) && !r_all;
    assign match    = l_rdata[dcp_pkg::LINE_W-1]
                      && (l_rdata[dcp_pkg::DIG_W-1:0]
                          == {r_item.bot, r_item.mid, r_item.top});
    assign take     = i_valid && (r_state == dcp_pkg::S_IDLE);
    assign out_free = !r_ovalid || i_ready;
    assign up       = (r_node - (LOG_LINES + 1)'(1)) >> 1;
    assign nxt      = {r_node[LOG_LINES-1:0], 1'b0} + (LOG_LINES + 1)'(1)
                      + (LOG_LINES + 1)'(t_rdata);

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_all   = r_all;
        n_node  = r_node;
        n_lvl   = r_lvl;
        n_res   = r_res;
        case (r_state)
            dcp_pkg::S_CLEAR: begin
                n_cnt = r_cnt + LOG_LINES'(1);
                if (&r_cnt) begin
                    n_state = dcp_pkg::S_IDLE;
                end
            end
            dcp_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = dcp_pkg::S_SEARCH;
                    n_cnt   = '0;
                    n_all   = 1'b0;
                end
            end
            dcp_pkg::S_SEARCH: begin
                if (!r_all) begin
                    n_cnt = r_cnt + LOG_LINES'(1);
                    n_all = &r_cnt;
                end
                if (r_rd_vld && match) begin
                    n_state   = dcp_pkg::S_AWAY;
                    n_node    = {1'b0, r_rd_idx} + INNER_N;
                    n_res.hit = 1'b1;
                    n_res.pos = l_rdata[dcp_pkg::LINE_W-2:dcp_pkg::DIG_W];
                end else if (r_rd_vld && (&r_rd_idx)) begin
                    n_state = dcp_pkg::S_WALK_RD;
                    n_node  = '0;
                    n_lvl   = '0;
                end
            end
            dcp_pkg::S_AWAY: begin
                n_node = up;
                if (up == '0) begin
                    n_state = dcp_pkg::S_DONE;
                end
            end
            dcp_pkg::S_WALK_RD: begin
                n_state = dcp_pkg::S_WALK_WR;
            end
            dcp_pkg::S_WALK_WR: begin
                n_node = nxt;
                if (r_lvl == LVL_W'(LOG_LINES - 1)) begin
                    n_state = dcp_pkg::S_INSERT;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = dcp_pkg::S_WALK_RD;
                end
            end
            dcp_pkg::S_INSERT: begin
                n_res.hit = 1'b0;
                n_res.pos = r_item.pos;
                n_state   = dcp_pkg::S_DONE;
            end
            dcp_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dcp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dcp_pkg::S_IDLE;
            end
        endcase
    end

    // RAM controls
    always_comb begin
        l_we    = 1'b0;
        l_waddr = r_cnt;
        l_wdata = '0;
        l_re    = issue;
        t_we    = 1'b0;
        t_waddr = r_cnt;
        t_wdata = 1'b0;
        t_re    = 1'b0;
        t_raddr = r_node[LOG_LINES-1:0];
        case (r_state)
            dcp_pkg::S_CLEAR: begin
                l_we = 1'b1;
                t_we = 1'b1;
            end
            dcp_pkg::S_AWAY: begin
                t_we    = 1'b1;
                t_waddr = up[LOG_LINES-1:0];
                t_wdata = r_node[0];
            end
            dcp_pkg::S_WALK_RD: begin
                t_re = 1'b1;
            end
            dcp_pkg::S_WALK_WR: begin
                t_we    = 1'b1;
                t_waddr = r_node[LOG_LINES-1:0];
                t_wdata = ~t_rdata;
            end
            dcp_pkg::S_INSERT: begin
                // leaf index = node - (LINES-1), i.e. node + 1 modulo LINES
                l_we    = 1'b1;
                l_waddr = r_node[LOG_LINES-1:0] + LOG_LINES'(1);
                l_wdata = {1'b1, r_item.pos, r_item.bot, r_item.mid, r_item.top};
            end
            default: begin
                l_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dcp_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_all    <= 1'b0;
            r_rd_vld <= 1'b0;
            r_lvl    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_all    <= n_all;
            r_rd_vld <= issue && (n_state == dcp_pkg::S_SEARCH);
            r_lvl    <= n_lvl;
            if ((r_state == dcp_pkg::S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
        r_node   <= n_node;
        r_res    <= n_res;
        if (take) begin
            r_item <= i_item;
        end
        if ((r_state == dcp_pkg::S_DONE) && out_free) begin
            r_ores <= r_res;
        end
    end

    assign o_ready = (r_state == dcp_pkg::S_IDLE);
    assign o_valid = r_ovalid;
    assign o_res   = r_ores;

`ifndef SYNTHESIS
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcp_pkg::S_CLEAR) |-> !take)
        else $error("item taken during clearing pass");
    a_tree_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(t_we && t_re))
        else $error("tree read and write in the same cycle");
    a_line_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_we |-> ((r_state == dcp_pkg::S_INSERT) || (r_state == dcp_pkg::S_CLEAR)))
        else $error("line written outside insert or clear");
    a_walk_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcp_pkg::S_WALK_WR) |-> (r_lvl < LVL_W'(LOG_LINES)))
        else $error("tree walk past leaf level");
`endif

endmodule

// ===== rtl/core/digest_cache_tree_plru.sv =====
// Digest cache, fully associative, 2**LOG_LINES lines, tree pseudo-LRU.
// A lookup sweeps the line RAM one line a cycle and stops at the first hit;
// a miss sweeps every line, then walks the tree to pick the victim line.
// One item at a time; a two-beat input queue and an output register decouple.
// Reset (synchronous, active low) starts a clearing pass of the line and
// tree RAMs; the engine takes no item until it ends, so at most two input
// beats are accepted into the queue meanwhile.
module digest_cache_tree_plru #(
    parameter int unsigned LOG_LINES = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // digest_top[31:0], digest_middle[95:32], digest_bottom[159:96],
    // new_position[223:160]
    input  logic [223:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // result_position[63:0]
    output logic [63:0]  m_axis_tdata,
    // hit[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready
);

    logic             q_valid;
    logic             q_ready;
    dcp_pkg::t_item   q_item;
    dcp_pkg::t_result res;

    dcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_axis_tdata),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    dcp_engine #(.LOG_LINES(LOG_LINES)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = res.pos;
    assign m_axis_tuser = res.hit;

endmodule

// ===== tb/digest_cache_checker.sv =====
// Checker for the digest cache: watches both streams, predicts each result
// with its own tree pseudo-LRU cache model and compares. Depends on dcp_pkg.
module digest_cache_checker #(
    parameter int unsigned LOG_LINES = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [223:0] i_s_tdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [63:0]  i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    output int           o_errors,
    output int           o_pending,
    output int           o_hits,
    output int           o_misses
);

    localparam int unsigned LINES = 1 << LOG_LINES;

    logic [dcp_pkg::DIG_W-1:0] line_dig [LINES];
    logic [dcp_pkg::POS_W-1:0] line_pos [LINES];
    logic                      line_vld [LINES];
    logic                      tree     [LINES];
    dcp_pkg::t_result          lookups_due[$];

    // one lookup: hit refreshes the path, miss walks and replaces the victim
    function automatic dcp_pkg::t_result cache_lookup(dcp_pkg::t_item it);
        dcp_pkg::t_result r;
        logic [dcp_pkg::DIG_W-1:0] d;
        int unsigned node, up, lv;
        d = {it.top, it.mid, it.bot};
        for (int i = 0; i < LINES; i++) begin
            if (line_vld[i] && line_dig[i] == d) begin
                node = i + LINES - 1;
                while (node != 0) begin
                    up = (node - 1) >> 1;
                    tree[up] = (node == 2 * up + 1);
                    node = up;
                end
                r.hit = 1'b1;
                r.pos = line_pos[i];
                return r;
            end
        end
        node = 0;
        for (lv = 0; lv < LOG_LINES; lv++) begin
            up = node;
            node = 2 * up + 1 + tree[up];
            tree[up] = ~tree[up];
        end
        node = node - (LINES - 1);
        line_dig[node] = d;
        line_pos[node] = it.pos;
        line_vld[node] = 1'b1;
        r.hit = 1'b0;
        r.pos = it.pos;
        return r;
    endfunction

    assign o_pending = lookups_due.size();

    always @(posedge i_clk) begin
        dcp_pkg::t_result r;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_vld[i] = 1'b0;
                tree[i]     = 1'b0;
            end
            lookups_due.delete();
            o_errors <= 0;
            o_hits   <= 0;
            o_misses <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                lookups_due.push_back(cache_lookup(dcp_pkg::t_item'(i_s_tdata)));
            // compare the result beat with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (lookups_due.size() == 0) begin
                    $display("%0t: unexpected result beat hit=%0b pos=%h",
                             $time, i_m_tuser, i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    r = lookups_due.pop_front();
                    if (r.hit) o_hits <= o_hits + 1;
                    else o_misses <= o_misses + 1;
                    if (r.hit !== i_m_tuser || r.pos !== i_m_tdata) begin
                        $display("%0t: mismatch expected hit=%0b pos=%h, got hit=%0b pos=%h",
                                 $time, r.hit, r.pos, i_m_tuser, i_m_tdata);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/digest_cache_tree_plru_tb.sv =====
// Testbench top for digest_cache_tree_plru: drives digest lookups in bursts,
// stalls the result stream and reports the verdict. Depends on dcp_pkg, checker.
module digest_cache_tree_plru_tb;

    localparam int unsigned LOG_LINES = 10;
    localparam int          N_RANDOM  = 400;
    localparam longint      CYCLE_CAP = 2000000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic [223:0]   s_tdata = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [63:0]    m_tdata;
    logic           m_tuser, m_tvalid;
    logic           m_tready = 1'b0;
    int             errors, pending, hits, misses;
    longint         cycles = 0;
    dcp_pkg::t_item seen[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    digest_cache_tree_plru #(.LOG_LINES(LOG_LINES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_tdata), .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready)
    );

    digest_cache_checker #(.LOG_LINES(LOG_LINES)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready), .o_errors(errors), .o_pending(pending),
        .o_hits(hits), .o_misses(misses)
    );

    // receiver stalls: windows of constant ready, otherwise ready at random
    always @(posedge i_clk) begin
        if (cycles % 3000 < 600) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // time-out guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one beat, held until accepted; gap only between bursts
    task automatic send_lookup(dcp_pkg::t_item it, bit hold_gap);
        s_tdata  <= it;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        seen.push_back(it);
        if (hold_gap) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    task automatic send_burst(dcp_pkg::t_item it);
        send_lookup(it, $urandom_range(0, 4) == 0);
    endtask

    initial begin
        dcp_pkg::t_item it;
        int             k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, repeats (hits), all-ones and zeros
        it = '0;
        send_burst(it);
        send_burst(it);
        it = '1;
        send_burst(it);
        send_burst(it);
        it = '0; it.top = '1;
        send_burst(it);
        it = '0; it.mid = '1;
        send_burst(it);
        it = '0; it.bot = '1;
        send_burst(it);
        it = '0; it.pos = '1;
        send_burst(it);
        it = '0; it.pos = 64'h1;
        send_burst(it);
        for (k = 0; k < 6; k++) begin
            it.top = $urandom(); it.mid = rand64(); it.bot = rand64(); it.pos = rand64();
            send_burst(it);
            send_burst(seen[$urandom_range(0, seen.size() - 1)]);
        end

        // random: about half repeats of earlier digests, fresh digests, some near-misses
        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    it.top = $urandom(); it.mid = rand64();
                    it.bot = rand64(); it.pos = rand64();
                end
                4, 5, 6: begin
                    it = seen[$urandom_range(0, seen.size() - 1)];
                    it.pos = rand64();
                end
                7: begin
                    it = seen[$urandom_range(0, seen.size() - 1)];
                    it.bot[$urandom_range(0, 63)] ^= 1'b1;
                end
                default: begin
                    it = seen[seen.size() - 1 - $urandom_range(0, seen.size() > 8 ? 7 : 0)];
                end
            endcase
            send_burst(it);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        $display("Covered %0d lookups: %0d hits and %0d inserts, with bursts and output stalls.",
                 seen.size(), hits, misses);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
